// ===== design/mdadv_pkg.sv =====
package mdadv_pkg;

   typedef enum logic [1:0] {
      KIND_LINK    = 2'd0,
      KIND_TEXT    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic [2:0] link_index;
      logic       ok;
      logic       established;
      logic [2:0] active_link;
      logic [6:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
      logic       text_present;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] idx;
   } link_hit_type;

   localparam int unsigned NUM_LINKS = 8;
   localparam logic [7:0] LINK_CODES [NUM_LINKS] =
      '{8'h56, 8'h53, 8'h48, 8'h47, 8'h43, 8'h32, 8'h58, 8'h49};  // V S H G C 2 X I

   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_EST   = 8'h45;  // 'E'
   localparam logic [7:0] CHAR_LOST  = 8'h4C;  // 'L'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

   localparam logic [3:0] POS_VERSION  = 4'd0;
   localparam logic [3:0] POS_STATE    = 4'd1;
   localparam logic [3:0] POS_LINK     = 4'd2;
   localparam logic [3:0] POS_HOUR_END = 4'd4;
   localparam logic [3:0] POS_MIN_END  = 4'd6;
   localparam logic [3:0] POS_TIME_END = 4'd8;
   localparam logic [3:0] MIN_LENGTH   = 4'd10;

   localparam logic [6:0] MAX_HOUR    = 7'd23;
   localparam logic [6:0] MAX_MIN_SEC = 7'd59;

   function automatic link_hit_type link_lookup(input logic [7:0] b);
      link_hit_type r;
      r = '0;
      for (int k = NUM_LINKS - 1; k >= 0; k--) begin
         if (LINK_CODES[k] == b) begin
            r.hit = 1'b1;
            r.idx = 3'(k);
         end
      end
      return r;
   endfunction

   // acc * 10 + d, kept to seven bits
   function automatic logic [6:0] mul10_add(input logic [6:0] acc, input logic [3:0] d);
      logic [10:0] t;
      t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {7'b0, d};
      return t[6:0];
   endfunction

endpackage

// ===== design/mdadv_req_if.sv =====
interface mdadv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_req;
   logic       end_of_message;

   modport source (output valid, output byte_req, output end_of_message, input ready);
   modport sink   (input valid, input byte_req, input end_of_message, output ready);
endinterface

// ===== design/mdadv_rsp_if.sv =====
interface mdadv_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic [2:0] link_index;
   logic       ok;
   logic       established;
   logic [2:0] active_link;
   logic [6:0] hour;
   logic [6:0] minute;
   logic [6:0] second;
   logic       text_present;
   logic       run_end;

   modport source (
      output valid, output kind, output value, output link_index, output ok,
      output established, output active_link, output hour, output minute,
      output second, output text_present, output run_end, input ready
   );
   modport sink (
      input valid, input kind, input value, input link_index, input ok,
      input established, input active_link, input hour, input minute,
      input second, input text_present, input run_end, output ready
   );
endinterface

// ===== design/media_advisory_parser.sv =====
// An accepted request's results are registered in a four-entry result queue.
// Throughput: one byte per cycle while input is ready; a final byte that also
// yields a link or text item produces two results, drained one per cycle while
// the sink is ready. Input is ready while the queue holds room for two results.
// Reset (synchronous, active high) clears the parser state and empties the queue.
module media_advisory_parser
   import mdadv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   mdadv_req_if.sink          req_bus,
   mdadv_rsp_if.source        rsp_bus
);

   logic [3:0] position_ff,    position_in;
   logic       in_text_ff,     in_text_in;
   logic       format_good_ff, format_good_in;
   logic       established_ff, established_in;
   logic [2:0] link_now_ff,    link_now_in;
   logic [6:0] hour_ff,        hour_in;
   logic [6:0] minute_ff,      minute_in;
   logic [6:0] second_ff,      second_in;
   logic       text_seen_ff,   text_seen_in;

   rsp_type    queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff,  count_in;

   logic       accept;
   logic       pop;
   logic       item_valid;
   logic       summary_valid;
   rsp_type    item;
   rsp_type    summary;

   assign accept = req_bus.valid & req_bus.ready;
   assign pop    = rsp_bus.valid & rsp_bus.ready;
   assign req_bus.ready = (count_ff < 3'd3);

   always_comb begin
      logic [7:0]   b;
      logic         isdig;
      logic [7:0]   diff;
      logic [3:0]   d;
      link_hit_type lk;
      logic         ok;

      b     = req_bus.byte_req;
      isdig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      diff  = b - CHAR_ZERO;
      d     = isdig ? diff[3:0] : 4'd0;
      lk    = link_lookup(b);

      position_in    = position_ff;
      in_text_in     = in_text_ff;
      format_good_in = format_good_ff;
      established_in = established_ff;
      link_now_in    = link_now_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      text_seen_in   = text_seen_ff;

      item       = '0;
      item_valid = 1'b0;
      summary    = '0;

      priority if (position_ff == POS_VERSION) begin
         if (b != CHAR_ZERO) format_good_in = 1'b0;
      end else if (position_ff == POS_STATE) begin
         if (b != CHAR_EST && b != CHAR_LOST) format_good_in = 1'b0;
         established_in = (b == CHAR_EST);
      end else if (position_ff == POS_LINK) begin
         if (!lk.hit) format_good_in = 1'b0;
         link_now_in = lk.hit ? lk.idx : 3'd0;
      end else if (position_ff <= POS_TIME_END) begin
         if (!isdig) format_good_in = 1'b0;
         priority if (position_ff <= POS_HOUR_END) begin
            hour_in = mul10_add(hour_ff, d);
         end else if (position_ff <= POS_MIN_END) begin
            minute_in = mul10_add(minute_ff, d);
         end else begin
            second_in = mul10_add(second_ff, d);
         end
      end else if (in_text_ff) begin
         item_valid   = 1'b1;
         item.kind    = KIND_TEXT;
         item.value   = b;
         text_seen_in = 1'b1;
      end else if (b == CHAR_SLASH) begin
         in_text_in = 1'b1;
      end else begin
         if (!lk.hit) begin
            format_good_in = 1'b0;
         end else begin
            item_valid      = 1'b1;
            item.kind       = KIND_LINK;
            item.value      = b;
            item.link_index = lk.idx;
         end
      end

      if (position_ff < MIN_LENGTH) position_in = position_ff + 4'd1;

      ok = format_good_in && (position_in >= MIN_LENGTH) && (hour_in <= MAX_HOUR) &&
           (minute_in <= MAX_MIN_SEC) && (second_in <= MAX_MIN_SEC);

      summary_valid        = req_bus.end_of_message;
      summary.kind         = KIND_SUMMARY;
      summary.ok           = ok;
      summary.established  = established_in;
      summary.active_link  = link_now_in;
      summary.hour         = hour_in;
      summary.minute       = minute_in;
      summary.second       = second_in;
      summary.text_present = text_seen_in;
      summary.run_end      = 1'b1;
      item.run_end         = !summary_valid;

      // start over for the next message
      if (summary_valid) begin
         position_in    = '0;
         in_text_in     = 1'b0;
         format_good_in = 1'b1;
         established_in = 1'b0;
         link_now_in    = '0;
         hour_in        = '0;
         minute_in      = '0;
         second_in      = '0;
         text_seen_in   = 1'b0;
      end
   end

   always_comb begin
      logic [2:0] pushes;
      pushes    = {2'b0, accept & item_valid} + {2'b0, accept & summary_valid};
      wr_ptr_in = wr_ptr_ff + pushes[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + pushes - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         in_text_ff     <= 1'b0;
         format_good_ff <= 1'b1;
         established_ff <= 1'b0;
         link_now_ff    <= '0;
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
         text_seen_ff   <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (accept) begin
            position_ff    <= position_in;
            in_text_ff     <= in_text_in;
            format_good_ff <= format_good_in;
            established_ff <= established_in;
            link_now_ff    <= link_now_in;
            hour_ff        <= hour_in;
            minute_ff      <= minute_in;
            second_ff      <= second_in;
            text_seen_ff   <= text_seen_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         if (item_valid) begin
            queue_ff[wr_ptr_ff] <= item;
            if (summary_valid) queue_ff[wr_ptr_ff + 2'd1] <= summary;
         end else if (summary_valid) begin
            queue_ff[wr_ptr_ff] <= summary;
         end
      end
   end

   assign rsp_bus.valid        = (count_ff != 3'd0);
   assign rsp_bus.kind         = queue_ff[rd_ptr_ff].kind;
   assign rsp_bus.value        = queue_ff[rd_ptr_ff].value;
   assign rsp_bus.link_index   = queue_ff[rd_ptr_ff].link_index;
   assign rsp_bus.ok           = queue_ff[rd_ptr_ff].ok;
   assign rsp_bus.established  = queue_ff[rd_ptr_ff].established;
   assign rsp_bus.active_link  = queue_ff[rd_ptr_ff].active_link;
   assign rsp_bus.hour         = queue_ff[rd_ptr_ff].hour;
   assign rsp_bus.minute       = queue_ff[rd_ptr_ff].minute;
   assign rsp_bus.second       = queue_ff[rd_ptr_ff].second;
   assign rsp_bus.text_present = queue_ff[rd_ptr_ff].text_present;
   assign rsp_bus.run_end      = queue_ff[rd_ptr_ff].run_end;

endmodule

// ===== tb/sv/advisory_check_pkg.sv =====
package advisory_check_pkg;
   import mdadv_pkg::*;

   class advisory_scoreboard;
      rsp_type    pending_results[$];
      int         errors;
      int         checked;

      logic [3:0] position;
      logic       in_text;
      logic       format_good;
      logic       established;
      logic [2:0] link_now;
      logic [6:0] hour_acc;
      logic [6:0] minute_acc;
      logic [6:0] second_acc;
      logic       text_seen;

      function new();
         errors  = 0;
         checked = 0;
         restart();
      endfunction

      function void restart();
         position    = '0;
         in_text     = 1'b0;
         format_good = 1'b1;
         established = 1'b0;
         link_now    = '0;
         hour_acc    = '0;
         minute_acc  = '0;
         second_acc  = '0;
         text_seen   = 1'b0;
      endfunction

      function int link_slot(logic [7:0] b);
         for (int k = 0; k < NUM_LINKS; k++) begin
            if (LINK_CODES[k] == b) begin
               return k;
            end
         end
         return -1;
      endfunction

      function logic [6:0] times_ten_plus(logic [6:0] acc, logic [3:0] d);
         return 7'(acc * 10 + d);
      endfunction

      // Advance the parser by one accepted request and queue what it yields.
      function void note_request(logic [7:0] b, logic eom);
         rsp_type    r;
         int         slot;
         int         produced;
         logic       is_digit;
         logic [3:0] digit;

         produced = 0;
         is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
         digit    = is_digit ? 4'(b - CHAR_ZERO) : 4'd0;

         if (position == POS_VERSION) begin
            if (b != CHAR_ZERO) format_good = 1'b0;
         end else if (position == POS_STATE) begin
            if (b != CHAR_EST && b != CHAR_LOST) format_good = 1'b0;
            established = (b == CHAR_EST);
         end else if (position == POS_LINK) begin
            slot = link_slot(b);
            if (slot < 0) begin
               format_good = 1'b0;
               link_now    = '0;
            end else begin
               link_now = 3'(slot);
            end
         end else if (position <= POS_TIME_END) begin
            if (!is_digit) format_good = 1'b0;
            if (position <= POS_HOUR_END) begin
               hour_acc = times_ten_plus(hour_acc, digit);
            end else if (position <= POS_MIN_END) begin
               minute_acc = times_ten_plus(minute_acc, digit);
            end else begin
               second_acc = times_ten_plus(second_acc, digit);
            end
         end else if (in_text) begin
            r         = '0;
            r.kind    = KIND_TEXT;
            r.value   = b;
            text_seen = 1'b1;
            pending_results.push_back(r);
            produced++;
         end else if (b == CHAR_SLASH) begin
            in_text = 1'b1;
         end else begin
            slot = link_slot(b);
            if (slot < 0) begin
               format_good = 1'b0;
            end else begin
               r            = '0;
               r.kind       = KIND_LINK;
               r.value      = b;
               r.link_index = 3'(slot);
               pending_results.push_back(r);
               produced++;
            end
         end

         if (position < MIN_LENGTH) position++;

         if (eom) begin
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.ok           = format_good && position >= MIN_LENGTH && hour_acc <= MAX_HOUR &&
                             minute_acc <= MAX_MIN_SEC && second_acc <= MAX_MIN_SEC;
            r.established  = established;
            r.active_link  = link_now;
            r.hour         = hour_acc;
            r.minute       = minute_acc;
            r.second       = second_acc;
            r.text_present = text_seen;
            pending_results.push_back(r);
            produced++;
            restart();
         end

         if (produced > 0) pending_results[pending_results.size() - 1].run_end = 1'b1;
      endfunction

      task report(string what);
         $display("mismatch: result %0d: %s", checked, what);
         errors++;
      endtask

      task compare_field(string name, int got_v, int want_v);
         if (got_v != want_v) report($sformatf("%s got %0d want %0d", name, got_v, want_v));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result of kind %0d", got.kind));
            return;
         end
         want = pending_results.pop_front();
         compare_field("kind", got.kind, want.kind);
         compare_field("value", got.value, want.value);
         compare_field("link_index", got.link_index, want.link_index);
         compare_field("ok", got.ok, want.ok);
         compare_field("established", got.established, want.established);
         compare_field("active_link", got.active_link, want.active_link);
         compare_field("hour", got.hour, want.hour);
         compare_field("minute", got.minute, want.minute);
         compare_field("second", got.second, want.second);
         compare_field("text_present", got.text_present, want.text_present);
         compare_field("run_end", got.run_end, want.run_end);
         checked++;
      endtask
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mdadv_pkg::*;
   import advisory_check_pkg::*;

   localparam int STALL_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset;
   logic quiet;
   int   sent;
   int   stall_cycles = 0;

   advisory_scoreboard book;

   mdadv_req_if req_bus ();
   mdadv_rsp_if rsp_bus ();

   media_advisory_parser uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= quiet || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind         = kind_type'(rsp_bus.kind);
         got.value        = rsp_bus.value;
         got.link_index   = rsp_bus.link_index;
         got.ok           = rsp_bus.ok;
         got.established  = rsp_bus.established;
         got.active_link  = rsp_bus.active_link;
         got.hour         = rsp_bus.hour;
         got.minute       = rsp_bus.minute;
         got.second       = rsp_bus.second;
         got.text_present = rsp_bus.text_present;
         got.run_end      = rsp_bus.run_end;
         book.check_response(got);
      end
   end

   // Count cycles in which neither side moves anything.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic eom);
      while (!quiet && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.byte_req       <= b;
      req_bus.end_of_message <= eom;
      do @(posedge clock); while (!req_bus.ready);
      book.note_request(b, eom);
      sent++;
   endtask

   task automatic send_chars(string s, logic eom);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], eom && (i == s.len() - 1));
      end
   endtask

   task automatic send_message(logic [7:0] msg[$]);
      for (int i = 0; i < msg.size(); i++) begin
         send_byte(msg[i], i == msg.size() - 1);
      end
   endtask

   // Hold the sender until every queued result has drained.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (book.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [7:0] msg[$];
      int         roll;
      int         len;
      int         hh;
      int         mm;
      int         ss;
      int         cut;
      bit         wide;
      bit         paused;

      book                   = new();
      quiet                  = 1'b0;
      sent                   = 0;
      paused                 = 1'b0;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.byte_req       <= '0;
      req_bus.end_of_message <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // valid message, time at its limits, zero and all-ones text bytes
      send_chars("0EV235959X/", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      // slash in header, bad link, non-digit, minute and second too large, zero byte
      send_chars("/EA2x6060", 1'b0);
      send_byte(8'h00, 1'b1);
      // hour too large, slash with no text after it
      send_chars("0LI240000/", 1'b1);
      // short message
      send_byte(CHAR_ZERO, 1'b1);
      wait_drained();

      while (sent < 1040) begin
         quiet = (sent >= 400) && (sent < 600);
         if (!paused && sent >= 700) begin
            wait_drained();
            paused = 1'b1;
         end
         msg.delete();
         roll = $urandom_range(99);
         if (roll < 15) begin
            len = $urandom_range(16, 1);
            repeat (len) msg.push_back(8'($urandom));
         end else begin
            wide = ($urandom_range(99) < 20);
            hh   = wide ? $urandom_range(99) : $urandom_range(23);
            mm   = wide ? $urandom_range(99) : $urandom_range(59);
            ss   = wide ? $urandom_range(99) : $urandom_range(59);
            msg.push_back(CHAR_ZERO);
            msg.push_back($urandom_range(1) ? CHAR_EST : CHAR_LOST);
            msg.push_back(LINK_CODES[$urandom_range(NUM_LINKS - 1)]);
            msg.push_back(8'(CHAR_ZERO + hh / 10));
            msg.push_back(8'(CHAR_ZERO + hh % 10));
            msg.push_back(8'(CHAR_ZERO + mm / 10));
            msg.push_back(8'(CHAR_ZERO + mm % 10));
            msg.push_back(8'(CHAR_ZERO + ss / 10));
            msg.push_back(8'(CHAR_ZERO + ss % 10));
            repeat ($urandom_range(4)) msg.push_back(LINK_CODES[$urandom_range(NUM_LINKS - 1)]);
            if ($urandom_range(1)) begin
               msg.push_back(CHAR_SLASH);
               repeat ($urandom_range(6)) msg.push_back(8'($urandom));
            end
            // corrupt one byte or cut the message short
            if (roll < 30) begin
               if ($urandom_range(1)) begin
                  msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
               end else begin
                  cut = $urandom_range(msg.size() - 1, 1);
                  while (msg.size() > cut) void'(msg.pop_back());
               end
            end
         end
         send_message(msg);
      end
      quiet = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (book.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== media_advisory_parser.f =====
design/mdadv_pkg.sv
design/mdadv_req_if.sv
design/mdadv_rsp_if.sv
design/media_advisory_parser.sv
tb/sv/advisory_check_pkg.sv
tb/sv/tb_top.sv
